// File: sv/pgws_pkg.sv
`timescale 1ns / 1ps

package pgws_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int ACC_W = 66;
   localparam int DIV_W = 64;
   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [15:0] TOLERANCE_RESET = 16'd7;

   localparam logic [3:0] CMD_SOLVE_SUN     = 4'd0;
   localparam logic [3:0] CMD_SOLVE_RING    = 4'd1;
   localparam logic [3:0] CMD_SOLVE_CARRIER = 4'd2;
   localparam logic [3:0] CMD_SOLVE_K       = 4'd3;
   localparam logic [3:0] CMD_CHECK         = 4'd4;
   localparam logic [3:0] CMD_DERIV_SUN     = 4'd5;
   localparam logic [3:0] CMD_DERIV_RING    = 4'd6;
   localparam logic [3:0] CMD_DERIV_CARRIER = 4'd7;
   localparam logic [3:0] CMD_DERIV_K       = 4'd8;
   localparam logic [3:0] CMD_CLEAR         = 4'd9;

   localparam logic MUL_RING_K   = 1'b0;
   localparam logic MUL_CARR_KM1 = 1'b1;

   typedef struct packed {
      logic load;
      logic mul_en;
      logic mul_sel;
      logic acc_init;
      logic acc_add;
      logic acc_sub;
      logic div_start;
      logic div_step;
      logic res_load;
   } ctrl_type;

   typedef struct packed {
      logic [3:0] cmd;
      logic       div_zero;
      logic       div_last;
   } stat_type;

endpackage

// File: sv/pgws_ctrl.sv
`timescale 1ns / 1ps

module pgws_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  pgws_pkg::stat_type  stat,
   output pgws_pkg::ctrl_type  ctrl
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL1 = 7'b0000010,
      ST_MUL2 = 7'b0000100,
      ST_SUM  = 7'b0001000,
      ST_PREP = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      ctrl     = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctrl.load = 1'b1;
               state_in  = ST_MUL1;
            end
         end
         ST_MUL1: begin
            ctrl.mul_en   = 1'b1;
            ctrl.acc_init = 1'b1;
            ctrl.mul_sel  = (stat.cmd == pgws_pkg::CMD_SOLVE_RING) ?
                            pgws_pkg::MUL_CARR_KM1 : pgws_pkg::MUL_RING_K;
            case (stat.cmd)
               pgws_pkg::CMD_SOLVE_SUN, pgws_pkg::CMD_SOLVE_RING,
               pgws_pkg::CMD_SOLVE_CARRIER, pgws_pkg::CMD_CHECK: state_in = ST_MUL2;
               pgws_pkg::CMD_SOLVE_K: state_in = ST_PREP;
               default: state_in = ST_DONE;
            endcase
         end
         ST_MUL2: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = pgws_pkg::MUL_CARR_KM1;
            if (stat.cmd == pgws_pkg::CMD_CHECK) begin
               ctrl.acc_sub = 1'b1;
            end else begin
               ctrl.acc_add = 1'b1;
            end
            case (stat.cmd)
               pgws_pkg::CMD_SOLVE_SUN, pgws_pkg::CMD_CHECK: state_in = ST_SUM;
               default: state_in = ST_PREP;
            endcase
         end
         ST_SUM: begin
            if (stat.cmd == pgws_pkg::CMD_CHECK) begin
               ctrl.acc_add = 1'b1;
            end else begin
               ctrl.acc_sub = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_PREP: begin
            ctrl.div_start = 1'b1;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_zero) begin
               state_in = ST_DONE;
            end else begin
               ctrl.div_step = 1'b1;
               if (stat.div_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ctrl.res_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (ctrl.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MUL1))
      else $error("accepted transaction did not start the sequence");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.res_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while a transaction was pending");
`endif

endmodule

// File: sv/pgws_datapath.sv
`timescale 1ns / 1ps

module pgws_datapath #(
   parameter int FRAC_BITS = pgws_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  pgws_pkg::ctrl_type ctrl,
   output pgws_pkg::stat_type stat,
   input  logic [3:0]         in_cmd,
   input  logic [127:0]       in_data,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata,
   output logic [31:0]        out_value,
   output logic [2:0]         out_flags
);

   localparam int AW = pgws_pkg::ACC_W;
   localparam int DW = pgws_pkg::DIV_W;
   localparam int CW = pgws_pkg::CNT_W;

   function automatic logic [31:0] sat32(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] hi;
      logic signed [AW-1:0] lo;
      hi = AW'(signed'(33'sh0_7FFF_FFFF));
      lo = -hi - AW'(signed'(2'sb01));
      if (v > hi) begin
         sat32 = 32'h7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'h8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   logic [3:0]           cmd_ff;
   logic signed [31:0]   sun_ff, ring_ff, carrier_ff, k_ff;
   logic signed [32:0]   km1_ff, diff_ff;
   logic signed [AW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [32:0]          rem_ff, rem_in;
   logic [DW-1:0]        quo_ff, quo_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [32:0]          dmag_ff;
   logic                 neg_ff;
   logic                 dz_ff, dz_in;
   logic [15:0]          tol_ff;
   logic                 sticky_ff, sticky_in;
   logic [31:0]          value_ff, value_in;
   logic [2:0]           flags_ff, flags_in;

   logic signed [31:0]   d_sun, d_ring, d_carrier, d_k;
   logic signed [32:0]   mul_a, mul_b;
   logic signed [AW-1:0] term, init_val;
   logic signed [32:0]   divisor;
   logic [32:0]          dmag;
   logic [AW-1:0]        nmag, nshift;
   logic [33:0]          rem_sh, rem_sub;
   logic [31:0]          qsat, kmag;
   logic                 cons;

   assign d_sun     = in_data[31:0];
   assign d_ring    = in_data[63:32];
   assign d_carrier = in_data[95:64];
   assign d_k       = in_data[127:96];

   assign mul_a   = (ctrl.mul_sel == pgws_pkg::MUL_CARR_KM1) ?
                    {carrier_ff[31], carrier_ff} : {ring_ff[31], ring_ff};
   assign mul_b   = (ctrl.mul_sel == pgws_pkg::MUL_CARR_KM1) ? km1_ff : {k_ff[31], k_ff};
   assign prod_in = ctrl.mul_en ? (mul_a * mul_b) : prod_ff;
   assign term    = prod_ff >>> FRAC_BITS;

   always_comb begin
      case (cmd_ff)
         pgws_pkg::CMD_SOLVE_RING, pgws_pkg::CMD_CHECK:
            init_val = {{(AW-32){sun_ff[31]}}, sun_ff};
         pgws_pkg::CMD_SOLVE_CARRIER:
            init_val = -{{(AW-32){sun_ff[31]}}, sun_ff};
         pgws_pkg::CMD_SOLVE_K:
            init_val = {{(AW-32){carrier_ff[31]}}, carrier_ff}
                     - {{(AW-32){sun_ff[31]}}, sun_ff};
         default: init_val = '0;
      endcase
   end

   always_comb begin
      if (ctrl.acc_init) begin
         acc_in = init_val;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + term;
      end else if (ctrl.acc_sub) begin
         acc_in = acc_ff - term;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_comb begin
      case (cmd_ff)
         pgws_pkg::CMD_SOLVE_RING:    divisor = {k_ff[31], k_ff};
         pgws_pkg::CMD_SOLVE_CARRIER: divisor = km1_ff;
         default:                     divisor = diff_ff;
      endcase
   end

   assign dmag    = divisor[32] ? 33'(-divisor) : 33'(divisor);
   assign nmag    = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
   assign nshift  = nmag << FRAC_BITS;
   assign rem_sh  = {rem_ff, quo_ff[DW-1]};
   assign rem_sub = rem_sh - {1'b0, dmag_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      dz_in  = dz_ff;
      if (ctrl.load) begin
         dz_in = 1'b0;
      end else if (ctrl.div_start) begin
         rem_in = '0;
         quo_in = nshift[DW-1:0];
         cnt_in = '0;
         dz_in  = (dmag == '0);
      end else if (ctrl.div_step) begin
         cnt_in = cnt_ff + CW'(1);
         if (!rem_sub[33]) begin
            rem_in = rem_sub[32:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[32:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (neg_ff) begin
         qsat = (quo_ff >= DW'(32'h8000_0000)) ? 32'h8000_0000 : -quo_ff[31:0];
      end else begin
         qsat = (quo_ff > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_ff[31:0];
      end
   end

   assign kmag = k_ff[31] ? -k_ff : k_ff;
   assign cons = (kmag > {16'd0, tol_ff}) && (nmag < AW'(tol_ff));

   always_comb begin
      value_in  = value_ff;
      flags_in  = flags_ff;
      sticky_in = sticky_ff;
      if (ctrl.res_load) begin
         sticky_in = (cmd_ff == pgws_pkg::CMD_CLEAR) ? 1'b1 : (dz_ff ? 1'b0 : sticky_ff);
         value_in  = '0;
         flags_in  = {sticky_in, 1'b0, dz_ff};
         case (cmd_ff)
            pgws_pkg::CMD_SOLVE_SUN: value_in = sat32(acc_ff);
            pgws_pkg::CMD_SOLVE_RING, pgws_pkg::CMD_SOLVE_CARRIER,
            pgws_pkg::CMD_SOLVE_K: value_in = dz_ff ? '0 : qsat;
            pgws_pkg::CMD_CHECK: begin
               value_in    = sat32(acc_ff);
               flags_in[1] = cons;
            end
            pgws_pkg::CMD_DERIV_SUN: value_in = sat32(AW'(1) <<< FRAC_BITS);
            pgws_pkg::CMD_DERIV_RING:
               value_in = sat32(-{{(AW-32){k_ff[31]}}, k_ff});
            pgws_pkg::CMD_DERIV_CARRIER:
               value_in = sat32({{(AW-33){km1_ff[32]}}, km1_ff});
            pgws_pkg::CMD_DERIV_K:
               value_in = sat32({{(AW-33){diff_ff[32]}}, diff_ff});
            default: value_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff     <= in_cmd;
         sun_ff     <= d_sun;
         ring_ff    <= d_ring;
         carrier_ff <= d_carrier;
         k_ff       <= d_k;
         km1_ff     <= {d_k[31], d_k} - (33'sd1 <<< FRAC_BITS);
         diff_ff    <= {d_carrier[31], d_carrier} - {d_ring[31], d_ring};
      end
      if (ctrl.div_start) begin
         dmag_ff <= dmag;
         neg_ff  <= acc_ff[AW-1] ^ divisor[32];
      end
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      value_ff <= value_in;
      flags_ff <= flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         dz_ff     <= 1'b0;
         tol_ff    <= pgws_pkg::TOLERANCE_RESET;
         sticky_ff <= 1'b1;
      end else begin
         cnt_ff    <= cnt_in;
         dz_ff     <= dz_in;
         sticky_ff <= sticky_in;
         if (csr_we) begin
            tol_ff <= csr_wdata;
         end
      end
   end

   assign stat.cmd      = cmd_ff;
   assign stat.div_zero = dz_ff;
   assign stat.div_last = (cnt_ff == CW'(DW - 1));
   assign out_value     = value_ff;
   assign out_flags     = flags_ff;

`ifndef SYNTH
   a_no_step_on_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl.div_step |-> !dz_ff)
      else $error("divider stepped with a zero divisor");
   a_zero_clears_sticky: assert property (@(posedge clock) disable iff (reset)
      (ctrl.res_load && dz_ff) |=> (!sticky_ff && !flags_ff[2] && flags_ff[0]))
      else $error("zero divisor did not clear the sticky status");
`endif

endmodule

// File: sv/planetary_gear_willis_solver.sv
`timescale 1ns / 1ps

// Willis relation solver for a planetary gear set in signed fixed point.
// The request channel carries one transaction per item: the command in
// req_tuser and the sun, ring, carrier speeds and ratio k in req_tdata.
// The response channel returns one transaction per request: the value in
// rsp_tdata and the division, consistency and sticky status flags in rsp_tuser.
// The tolerance register is written through csr_we and csr_wdata; the user
// must write it only while idle, which the block itself does not enforce.
// A request is taken only when the sequencer is idle, one item at a time.
// Derivative, clear and unused commands go to the response after the first
// multiply state; solve-for-sun and check take two multiply steps and a sum;
// solve-for-ring and solve-for-carrier take two multiply steps and
// solve-for-k one, then the 64 steps of the shared radix-2 divider, one
// quotient bit a cycle; with a zero divisor the steps are skipped.
// The multiplier is shared and registered, so products are formed one per cycle.
// A finished response sits in an output register, and the block takes the
// next request while the receiver stalls; a second result waits until the
// first is taken.
// Synchronous reset returns to idle, sets tolerance to 7 and status_ok to 1.

module planetary_gear_willis_solver #(
   parameter int FRAC_BITS = pgws_pkg::FRAC_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // w_sun, w_ring, w_carrier, ratio_k
   input  logic [3:0]   req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,  // value
   output logic [2:0]   rsp_tuser,  // div_by_zero, consistent, status_ok
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);

   pgws_pkg::ctrl_type ctrl;
   pgws_pkg::stat_type stat;

   pgws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   pgws_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .stat      (stat),
      .in_cmd    (req_tuser),
      .in_data   (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .out_value (rsp_tdata),
      .out_flags (rsp_tuser)
   );

endmodule
